FILE: design/rrac_pkg.sv
// ----------------------------------------------------------------------------
// Rounded rectangle compositor package
// Beat types, register indexes and arithmetic widths shared by the design.
// ----------------------------------------------------------------------------
package rrac_pkg;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  dst_blue;
    logic [7:0]  dst_green;
    logic [7:0]  dst_red;
    logic [7:0]  dst_alpha;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       touched;
  } out_beat_t;

  localparam logic [2:0] REG_RECT_LEFT     = 3'd0;
  localparam logic [2:0] REG_RECT_TOP      = 3'd1;
  localparam logic [2:0] REG_RECT_WIDTH    = 3'd2;
  localparam logic [2:0] REG_RECT_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_FILL_RGBA     = 3'd4;
  localparam logic [2:0] REG_CORNER_RADIUS = 3'd5;
  localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd6;
  localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd7;

  // Square root: radicand is the squared distance with 16 fraction bits.
  localparam int unsigned SQ_ROOT_W = 21;
  localparam int unsigned SQ_VAL_W  = 2 * SQ_ROOT_W;

  // Channel division: quotient bits, dividend and divisor widths.
  localparam int unsigned DV_QUO_W = 9;
  localparam int unsigned DV_DVD_W = 26;
  localparam int unsigned DV_DVS_W = 17;

endpackage

FILE: design/rrac_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined square root
// Restoring integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module rrac_sqrt (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [rrac_pkg::SQ_VAL_W-1:0]  val_i,
  output logic [rrac_pkg::SQ_ROOT_W-1:0] root_o
);

  localparam int unsigned N  = rrac_pkg::SQ_ROOT_W;
  localparam int unsigned VW = rrac_pkg::SQ_VAL_W;
  localparam int unsigned RW = N + 3;

  logic [RW-1:0] rem_q  [0:N-1];
  logic [N-1:0]  root_q [0:N-1];
  logic [VW-1:0] v_q    [0:N-2];

  logic [RW-1:0] rem_s   [0:N-1];
  logic [N-1:0]  root_s  [0:N-1];
  logic [VW-1:0] v_s     [0:N-1];
  logic [RW-1:0] r2_c    [0:N-1];
  logic [RW-1:0] trial_c [0:N-1];
  logic [RW-1:0] rem_d   [0:N-1];
  logic [N-1:0]  root_d  [0:N-1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign v_s[0]    = val_i;

  for (genvar k = 1; k < N; k++) begin : g_link
    assign rem_s[k]  = rem_q[k-1];
    assign root_s[k] = root_q[k-1];
    assign v_s[k]    = v_q[k-1];
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      r2_c[k]    = {rem_s[k][RW-3:0], v_s[k][VW-1 -: 2]};
      trial_c[k] = RW'({root_s[k], 2'b01});
      if (r2_c[k] >= trial_c[k]) begin
        rem_d[k]  = r2_c[k] - trial_c[k];
        root_d[k] = {root_s[k][N-2:0], 1'b1};
      end else begin
        rem_d[k]  = r2_c[k];
        root_d[k] = {root_s[k][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
      for (int k = 0; k < N - 1; k++) begin
        v_q[k] <= {v_s[k][VW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

FILE: design/rrac_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rrac_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rrac_pkg::DV_DVD_W-1:0] dvd_i,
  input  logic [rrac_pkg::DV_DVS_W-1:0] dvs_i,
  output logic [rrac_pkg::DV_QUO_W-1:0] quo_o
);

  localparam int unsigned N  = rrac_pkg::DV_QUO_W;
  localparam int unsigned DW = rrac_pkg::DV_DVD_W;
  localparam int unsigned SW = rrac_pkg::DV_DVS_W;
  localparam int unsigned CW = SW + N;

  logic [DW-1:0] rem_q [0:N-1];
  logic [N-1:0]  quo_q [0:N-1];
  logic [SW-1:0] dvs_q [0:N-2];

  logic [DW-1:0] rem_s [0:N-1];
  logic [N-1:0]  quo_s [0:N-1];
  logic [SW-1:0] dvs_s [0:N-1];
  logic [CW-1:0] sub_c [0:N-1];
  logic [DW-1:0] rem_d [0:N-1];
  logic [N-1:0]  quo_d [0:N-1];

  assign rem_s[0] = dvd_i;
  assign quo_s[0] = '0;
  assign dvs_s[0] = dvs_i;

  for (genvar k = 1; k < N; k++) begin : g_link
    assign rem_s[k] = rem_q[k-1];
    assign quo_s[k] = quo_q[k-1];
    assign dvs_s[k] = dvs_q[k-1];
  end

  // The remainder stays below the divisor shifted one place further, so the
  // quotient never needs more than N bits.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      sub_c[k] = CW'(dvs_s[k]) << (N - 1 - k);
      if (CW'(rem_s[k]) >= sub_c[k]) begin
        rem_d[k] = rem_s[k] - DW'(sub_c[k]);
        quo_d[k] = {quo_s[k][N-2:0], 1'b1};
      end else begin
        rem_d[k] = rem_s[k];
        quo_d[k] = {quo_s[k][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
      for (int k = 0; k < N - 1; k++) begin
        dvs_q[k] <= dvs_s[k];
      end
    end
  end

  assign quo_o = quo_q[N-1];

endmodule

FILE: design/rounded_rect_alpha_compositor.sv
// ----------------------------------------------------------------------------
// Rounded rectangle alpha compositor
// Throughput: one beat per cycle while the output is not stalled; the 21-stage square root
// and 9-stage dividers are fully pipelined and the whole pipe advances together.
// Reset clears the valid bits and sets the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module rounded_rect_alpha_compositor #(
  parameter int MAX_CANVAS = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rrac_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rrac_pkg::out_beat_t out_beat_o
);

  localparam int unsigned SQ_N = rrac_pkg::SQ_ROOT_W;
  localparam int unsigned DV_N = rrac_pkg::DV_QUO_W;
  localparam int unsigned VN   = 5 + SQ_N + 3 + DV_N;

  typedef struct packed {
    rrac_pkg::in_beat_t beat;
    logic               touched;
    logic               band;
    logic [11:0]        rad;
  } sq_ctx_t;

  typedef struct packed {
    rrac_pkg::in_beat_t beat;
    logic               touched;
    logic [7:0]         alpha;
    logic               tiny;
    logic [7:0]         oa;
  } dv_ctx_t;

  // Configuration registers.
  logic [12:0] left_q, top_q, w_q, h_q, cw_q, ch_q;
  logic [31:0] rgba_q;
  logic [11:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      w_q      <= '0;
      h_q      <= '0;
      rgba_q   <= '0;
      radius_q <= '0;
      cw_q     <= 13'd4096;
      ch_q     <= 13'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rrac_pkg::REG_RECT_LEFT:     left_q   <= cfg_data_i[12:0];
        rrac_pkg::REG_RECT_TOP:      top_q    <= cfg_data_i[12:0];
        rrac_pkg::REG_RECT_WIDTH:    w_q      <= cfg_data_i[12:0];
        rrac_pkg::REG_RECT_HEIGHT:   h_q      <= cfg_data_i[12:0];
        rrac_pkg::REG_FILL_RGBA:     rgba_q   <= cfg_data_i;
        rrac_pkg::REG_CORNER_RADIUS: radius_q <= cfg_data_i[11:0];
        rrac_pkg::REG_CANVAS_WIDTH:  cw_q     <= cfg_data_i[12:0];
        rrac_pkg::REG_CANVAS_HEIGHT: ch_q     <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  logic [7:0] fill_r, fill_g, fill_b, fill_a;
  assign fill_r = rgba_q[7:0];
  assign fill_g = rgba_q[15:8];
  assign fill_b = rgba_q[23:16];
  assign fill_a = rgba_q[31:24];

  // Pipeline control: every stage moves when the output slot is free.
  logic          adv;
  logic [VN-1:0] vld_q;
  logic          out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[VN-2:0], in_valid_i};
      out_valid_q <= vld_q[VN-1];
    end
  end

  // Stage 1: input register.
  rrac_pkg::in_beat_t s1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= in_beat_i;
    end
  end

  // Stage 2: canvas and rectangle tests, radius clamp.
  logic signed [14:0] left_e, top_e, right_e, bot_e, x_e, y_e;
  logic [12:0]        cw_lim, ch_lim, min_wh;
  logic [11:0]        maxr, rad_c;
  logic               inside_c;

  assign left_e  = {{2{left_q[12]}}, left_q};
  assign top_e   = {{2{top_q[12]}}, top_q};
  assign right_e = left_e + $signed({2'b00, w_q});
  assign bot_e   = top_e + $signed({2'b00, h_q});
  assign x_e     = $signed({3'b000, s1_q.pixel_x});
  assign y_e     = $signed({3'b000, s1_q.pixel_y});
  assign cw_lim  = (32'(cw_q) > 32'(MAX_CANVAS)) ? 13'(MAX_CANVAS) : cw_q;
  assign ch_lim  = (32'(ch_q) > 32'(MAX_CANVAS)) ? 13'(MAX_CANVAS) : ch_q;
  assign min_wh  = (w_q < h_q) ? w_q : h_q;
  assign maxr    = min_wh[12:1];
  assign rad_c   = (radius_q > maxr) ? maxr : radius_q;
  assign inside_c = ({1'b0, s1_q.pixel_x} < cw_lim) && ({1'b0, s1_q.pixel_y} < ch_lim) &&
                    (x_e >= left_e) && (x_e < right_e) && (y_e >= top_e) && (y_e < bot_e);

  rrac_pkg::in_beat_t s2_beat_q;
  logic               s2_inside_q;
  logic [11:0]        s2_rad_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_beat_q   <= s1_q;
      s2_inside_q <= inside_c;
      s2_rad_q    <= rad_c;
    end
  end

  // Stage 3: corner selection and half-pixel offsets from the corner center.
  logic signed [15:0] rx0, rx1, ry0, ry1, x2, y2, cx, cy, dx, dy;
  logic               oh, ov, corner_c;
  logic [12:0]        adx, ady;

  assign x2  = $signed({4'b0000, s2_beat_q.pixel_x});
  assign y2  = $signed({4'b0000, s2_beat_q.pixel_y});
  assign rx0 = 16'(left_e) + $signed({4'b0000, s2_rad_q});
  assign rx1 = 16'(right_e) - $signed({4'b0000, s2_rad_q});
  assign ry0 = 16'(top_e) + $signed({4'b0000, s2_rad_q});
  assign ry1 = 16'(bot_e) - $signed({4'b0000, s2_rad_q});
  assign oh  = (x2 < rx0) || (x2 >= rx1);
  assign ov  = (y2 < ry0) || (y2 >= ry1);
  assign corner_c = (s2_rad_q != '0) && oh && ov;
  assign cx  = (x2 < rx0) ? rx0 : rx1;
  assign cy  = (y2 < ry0) ? ry0 : ry1;
  assign dx  = ((x2 - cx) <<< 1) + 16'sd1;
  assign dy  = ((y2 - cy) <<< 1) + 16'sd1;
  // Inside a corner both offsets stay below twice the radius, so 13 bits suffice.
  assign adx = dx[15] ? 13'(-dx) : dx[12:0];
  assign ady = dy[15] ? 13'(-dy) : dy[12:0];

  rrac_pkg::in_beat_t s3_beat_q;
  logic               s3_inside_q, s3_corner_q;
  logic [12:0]        s3_adx_q, s3_ady_q;
  logic [11:0]        s3_rad_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_beat_q   <= s2_beat_q;
      s3_inside_q <= s2_inside_q;
      s3_corner_q <= corner_c;
      s3_adx_q    <= adx;
      s3_ady_q    <= ady;
      s3_rad_q    <= s2_rad_q;
    end
  end

  // Stage 4: squares of the offsets and of the outer and inner band edges.
  logic [12:0] r2p1, r2m1;
  assign r2p1 = {s3_rad_q, 1'b1};
  assign r2m1 = {s3_rad_q, 1'b0} - 13'd1;

  rrac_pkg::in_beat_t s4_beat_q;
  logic               s4_inside_q, s4_corner_q;
  logic [25:0]        s4_dx2_q, s4_dy2_q;
  logic [25:0]        s4_outer_q, s4_inner_q;
  logic [11:0]        s4_rad_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_beat_q   <= s3_beat_q;
      s4_inside_q <= s3_inside_q;
      s4_corner_q <= s3_corner_q;
      s4_dx2_q    <= s3_adx_q * s3_adx_q;
      s4_dy2_q    <= s3_ady_q * s3_ady_q;
      s4_outer_q  <= r2p1 * r2p1;
      s4_inner_q  <= r2m1 * r2m1;
      s4_rad_q    <= s3_rad_q;
    end
  end

  // Stage 5: squared distance and band classification. Only distances inside
  // the outer edge have their square root used, and those fit in 26 bits.
  logic [26:0] dist_c;
  logic        skip_c;
  assign dist_c = 27'(s4_dx2_q) + 27'(s4_dy2_q);
  assign skip_c = s4_corner_q && (dist_c > 27'(s4_outer_q));

  sq_ctx_t     s5_q;
  logic [25:0] s5_dist_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_q.beat    <= s4_beat_q;
      s5_q.touched <= s4_inside_q && !skip_c;
      s5_q.band    <= s4_corner_q && !skip_c && (dist_c > 27'(s4_inner_q));
      s5_q.rad     <= s4_rad_q;
      s5_dist_q    <= dist_c[25:0];
    end
  end

  // Square root of the distance with 16 fraction bits, context alongside.
  logic [SQ_N-1:0] root;
  rrac_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .val_i  ({s5_dist_q, 16'h0000}),
    .root_o (root)
  );

  sq_ctx_t sq_ctx_q [0:SQ_N-1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_ctx_q[0] <= s5_q;
      for (int k = 1; k < SQ_N; k++) begin
        sq_ctx_q[k] <= sq_ctx_q[k-1];
      end
    end
  end

  // Stage 6: coverage in the edge band and the effective fill alpha.
  sq_ctx_t     sq_out;
  logic [20:0] lim, cov_raw;
  logic [9:0]  cov;
  logic [18:0] ea;
  assign sq_out  = sq_ctx_q[SQ_N-1];
  assign lim     = {sq_out.rad, 1'b1, 8'h00};
  assign cov_raw = (root >= lim) ? '0 : lim - root;
  assign cov     = (cov_raw > 21'd512) ? 10'd512 : cov_raw[9:0];
  assign ea      = (19'(fill_a) * 19'(cov) + 19'd256) >> 9;

  rrac_pkg::in_beat_t s6_beat_q;
  logic               s6_touched_q;
  logic [7:0]         s6_alpha_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_beat_q    <= sq_out.beat;
      s6_touched_q <= sq_out.touched;
      s6_alpha_q   <= sq_out.band ? ea[7:0] : fill_a;
    end
  end

  // Stage 7: source and destination weights.
  logic [7:0]  ia;
  logic [15:0] ws_c, wd_c;
  assign ia   = 8'd255 - s6_alpha_q;
  assign ws_c = {s6_alpha_q, 8'h00} - 16'(s6_alpha_q);
  assign wd_c = s6_beat_q.dst_alpha * ia;

  rrac_pkg::in_beat_t s7_beat_q;
  logic               s7_touched_q;
  logic [7:0]         s7_alpha_q;
  logic [15:0]        s7_ws_q, s7_wd_q, s7_n_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_beat_q    <= s6_beat_q;
      s7_touched_q <= s6_touched_q;
      s7_alpha_q   <= s6_alpha_q;
      s7_ws_q      <= ws_c;
      s7_wd_q      <= wd_c;
      s7_n_q       <= ws_c + wd_c;
    end
  end

  // Stage 8: weighted channel sums as doubled dividends with rounding.
  logic [7:0]  src_c [0:2];
  logic [7:0]  dst_c [0:2];
  logic [23:0] num_c [0:2];
  logic [25:0] oa_prod;

  assign src_c[0] = fill_b;
  assign src_c[1] = fill_g;
  assign src_c[2] = fill_r;
  assign dst_c[0] = s7_beat_q.dst_blue;
  assign dst_c[1] = s7_beat_q.dst_green;
  assign dst_c[2] = s7_beat_q.dst_red;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = 24'(src_c[i]) * 24'(s7_ws_q) + 24'(dst_c[i]) * 24'(s7_wd_q);
    end
  end

  // Divide by 255 via multiply by 257: exact for these sums.
  assign oa_prod = (26'(s7_n_q) + 26'd128) * 26'd257;

  dv_ctx_t     s8_q;
  logic [25:0] s8_dvd_q [0:2];
  logic [16:0] s8_dvs_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_q.beat    <= s7_beat_q;
      s8_q.touched <= s7_touched_q;
      s8_q.alpha   <= s7_alpha_q;
      s8_q.tiny    <= (s7_n_q <= 16'd6);
      s8_q.oa      <= oa_prod[23:16];
      s8_dvs_q     <= {s7_n_q, 1'b0};
      for (int i = 0; i < 3; i++) begin
        s8_dvd_q[i] <= {1'b0, num_c[i], 1'b0} + 26'(s7_n_q);
      end
    end
  end

  // Per-channel dividers.
  logic [DV_N-1:0] quo [0:2];
  for (genvar i = 0; i < 3; i++) begin : g_div
    rrac_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .dvd_i (s8_dvd_q[i]),
      .dvs_i (s8_dvs_q),
      .quo_o (quo[i])
    );
  end

  dv_ctx_t dv_ctx_q [0:DV_N-1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_ctx_q[0] <= s8_q;
      for (int k = 1; k < DV_N; k++) begin
        dv_ctx_q[k] <= dv_ctx_q[k-1];
      end
    end
  end

  // Output stage: select pass-through, replace, clear or blended result.
  dv_ctx_t             dv_out;
  logic [7:0]          ch_c [0:2];
  rrac_pkg::out_beat_t out_d;
  rrac_pkg::out_beat_t out_q;

  assign dv_out = dv_ctx_q[DV_N-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch_c[i] = (quo[i] > 9'd255) ? 8'd255 : quo[i][7:0];
    end
  end

  always_comb begin
    out_d.out_blue  = dv_out.beat.dst_blue;
    out_d.out_green = dv_out.beat.dst_green;
    out_d.out_red   = dv_out.beat.dst_red;
    out_d.out_alpha = dv_out.beat.dst_alpha;
    out_d.touched   = dv_out.touched;
    if (dv_out.touched && (dv_out.alpha != 8'd0)) begin
      if (dv_out.alpha == 8'd255) begin
        out_d.out_blue  = fill_b;
        out_d.out_green = fill_g;
        out_d.out_red   = fill_r;
        out_d.out_alpha = 8'd255;
      end else if (dv_out.tiny) begin
        out_d.out_blue  = 8'd0;
        out_d.out_green = 8'd0;
        out_d.out_red   = 8'd0;
        out_d.out_alpha = 8'd0;
      end else begin
        out_d.out_blue  = ch_c[0];
        out_d.out_green = ch_c[1];
        out_d.out_red   = ch_c[2];
        out_d.out_alpha = dv_out.oa;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule
